[rtl/core/mexp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants, microcode word layout and control store of the modular
// exponentiation unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int EXP_BITS_DEFAULT = 63;
   localparam int MOD_BITS_DEFAULT = 31;
   localparam longint unsigned MODULUS_RESET = 64'd1000000007;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_MODULUS = 1'b0;

   localparam int UPC_BITS = 3;
   typedef logic [UPC_BITS-1:0] upc_type;

   typedef enum logic [2:0] {
      OP_ACCEPT,
      OP_NOP,
      OP_LOAD_BASE,
      OP_MULTIPLY,
      OP_REDUCE,
      OP_RESPOND
   } uop_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_MOD_SMALL,
      COND_EXP_ZERO
   } ucond_type;

   typedef enum logic {
      WB_BASE,
      WB_STEP
   } uwb_type;

   typedef struct packed {
      uop_type   op;
      ucond_type cond;
      uwb_type   wb;
      upc_type   target;
   } uword_type;

   localparam upc_type UPC_ACCEPT   = 3'd0;
   localparam upc_type UPC_CHECK    = 3'd1;
   localparam upc_type UPC_LOAD     = 3'd2;
   localparam upc_type UPC_RED_BASE = 3'd3;
   localparam upc_type UPC_LOOP     = 3'd4;
   localparam upc_type UPC_MULTIPLY = 3'd5;
   localparam upc_type UPC_RED_STEP = 3'd6;
   localparam upc_type UPC_DONE     = 3'd7;

   // control store: one word per step
   function automatic uword_type ucode_rom(input upc_type upc);
      uword_type w;
      case (upc)
         UPC_ACCEPT:   w = '{OP_ACCEPT,    COND_NONE,      WB_BASE, UPC_ACCEPT};
         UPC_CHECK:    w = '{OP_NOP,       COND_MOD_SMALL, WB_BASE, UPC_DONE};
         UPC_LOAD:     w = '{OP_LOAD_BASE, COND_NONE,      WB_BASE, UPC_ACCEPT};
         UPC_RED_BASE: w = '{OP_REDUCE,    COND_NONE,      WB_BASE, UPC_ACCEPT};
         UPC_LOOP:     w = '{OP_NOP,       COND_EXP_ZERO,  WB_STEP, UPC_DONE};
         UPC_MULTIPLY: w = '{OP_MULTIPLY,  COND_NONE,      WB_STEP, UPC_ACCEPT};
         UPC_RED_STEP: w = '{OP_REDUCE,    COND_ALWAYS,    WB_STEP, UPC_LOOP};
         UPC_DONE:     w = '{OP_RESPOND,   COND_ALWAYS,    WB_STEP, UPC_ACCEPT};
         default:      w = '{OP_NOP,       COND_ALWAYS,    WB_BASE, UPC_ACCEPT};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

[rtl/core/modular_exponentiation_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Raises a base to an exponent modulo a programmable modulus by
// square-and-multiply, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  req_     | in        | tdata = base_value, exponent
//  rsp_     | out       | tdata = power
//  csr_     | in/out    | APB register port, modulus at byte address 0
//
//  Each exponent bit up to the highest set one (none for a zero exponent) costs
//  a test, a multiply and a bit-serial reduction of the 2*MOD_BITS-bit
//  products (lanes: accumulate, square). A modulus below two goes straight
//  to the response.
//  Reset clears the sequencer, the output valid and loads the modulus reset.
//  A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit
   import mexp_pkg::*;
#(
   parameter int EXP_BITS = EXP_BITS_DEFAULT,
   parameter int MOD_BITS = MOD_BITS_DEFAULT,
   localparam int REQ_DATA_BITS = ((MOD_BITS + EXP_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((MOD_BITS + 7) / 8) * 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,   // base_value, exponent
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,   // power
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   localparam int PROD_BITS = 2 * MOD_BITS;
   localparam int CNT_BITS  = $clog2(PROD_BITS);
   localparam logic [CNT_BITS-1:0] RED_LAST = CNT_BITS'(PROD_BITS - 1);

   // configuration
   logic [MOD_BITS-1:0] mod_ff;
   logic [MOD_BITS-1:0] mod_in;
   logic                csr_write;
   logic                csr_sel_mod;

   // sequencer
   upc_type   upc_ff;
   upc_type   upc_in;
   uword_type uword;
   logic      op_done;
   logic      cond_true;

   // datapath
   logic [MOD_BITS-1:0]  base_ff;
   logic [EXP_BITS-1:0]  exp_ff;
   logic [MOD_BITS-1:0]  acc_ff;
   logic [MOD_BITS-1:0]  sq_ff;
   logic [PROD_BITS-1:0] prod_ff [2];
   logic [MOD_BITS-1:0]  rem_ff  [2];
   logic [MOD_BITS-1:0]  rem_in  [2];
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 mod_small;
   logic                 slot_free;

   // output register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   // ---------------------------------------------------------------- csr
   assign csr_pready  = 1'b1;
   assign csr_sel_mod = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_MODULUS);
   assign csr_write   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata  = csr_sel_mod ? CSR_DATA_BITS'(mod_ff) : '0;
   assign mod_in      = (csr_write && csr_sel_mod) ? csr_pwdata[MOD_BITS-1:0] : mod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_BITS'(MODULUS_RESET);
      end else begin
         mod_ff <= mod_in;
      end
   end

   // ---------------------------------------------------------- sequencer
   assign uword     = ucode_rom(upc_ff);
   assign mod_small = (mod_ff < MOD_BITS'(2));
   assign slot_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      case (uword.op)
         OP_ACCEPT:  op_done = req_tvalid;
         OP_REDUCE:  op_done = (cnt_ff == RED_LAST);
         OP_RESPOND: op_done = slot_free;
         default:    op_done = 1'b1;
      endcase
      case (uword.cond)
         COND_ALWAYS:    cond_true = 1'b1;
         COND_MOD_SMALL: cond_true = mod_small;
         COND_EXP_ZERO:  cond_true = (exp_ff == '0);
         default:        cond_true = 1'b0;
      endcase
      if (!op_done) begin
         upc_in = upc_ff;
      end else if (cond_true) begin
         upc_in = uword.target;
      end else begin
         upc_in = upc_ff + upc_type'(1);
      end
   end

   assign rsp_valid_in = (uword.op == OP_RESPOND && slot_free) ? 1'b1
                        : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (uword.op == OP_ACCEPT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------ reducer
   // restoring reduction, one product bit per cycle, MSB first
   always_comb begin
      logic [MOD_BITS:0] trial;
      logic [MOD_BITS:0] diff;
      for (int i = 0; i < 2; i++) begin
         trial     = {rem_ff[i], prod_ff[i][PROD_BITS-1]};
         diff      = trial - {1'b0, mod_ff};
         rem_in[i] = (trial >= {1'b0, mod_ff}) ? diff[MOD_BITS-1:0]
                                               : trial[MOD_BITS-1:0];
      end
   end

   // ----------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      case (uword.op)
         OP_ACCEPT: begin
            if (req_tvalid) begin
               base_ff <= req_tdata[MOD_BITS-1:0];
               exp_ff  <= req_tdata[MOD_BITS +: EXP_BITS];
               acc_ff  <= MOD_BITS'(1);
            end
         end
         OP_LOAD_BASE: begin
            prod_ff[0] <= PROD_BITS'(base_ff);
            prod_ff[1] <= PROD_BITS'(base_ff);
            rem_ff[0]  <= '0;
            rem_ff[1]  <= '0;
            cnt_ff     <= '0;
         end
         OP_MULTIPLY: begin
            prod_ff[0] <= PROD_BITS'(acc_ff) * PROD_BITS'(sq_ff);
            prod_ff[1] <= PROD_BITS'(sq_ff) * PROD_BITS'(sq_ff);
            rem_ff[0]  <= '0;
            rem_ff[1]  <= '0;
            cnt_ff     <= '0;
         end
         OP_REDUCE: begin
            prod_ff[0] <= prod_ff[0] << 1;
            prod_ff[1] <= prod_ff[1] << 1;
            rem_ff[0]  <= rem_in[0];
            rem_ff[1]  <= rem_in[1];
            cnt_ff     <= cnt_ff + CNT_BITS'(1);
            if (op_done) begin
               if (uword.wb == WB_BASE) begin
                  sq_ff <= rem_in[0];
               end else begin
                  if (exp_ff[0]) begin
                     acc_ff <= rem_in[0];
                  end
                  sq_ff  <= rem_in[1];
                  exp_ff <= exp_ff >> 1;
               end
            end
         end
         OP_RESPOND: begin
            if (slot_free) begin
               rsp_data_ff <= mod_small ? '0 : RSP_DATA_BITS'(acc_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // --------------------------------------------------------- assertions
   a_accept_enters_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (upc_ff == UPC_CHECK && acc_ff == MOD_BITS'(1)))
      else $error("transfer did not start the sequence");

   a_valid_from_respond: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(uword.op == OP_RESPOND))
      else $error("result raised outside respond step");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && upc_ff == UPC_ACCEPT))
      else $error("reset did not clear sequencer");

endmodule
`default_nettype wire

[tb/sv/tb_modular_exponentiation_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_unit
// Checks the modular exponentiation unit against a square-and-multiply
// predictor, across several modulus settings with random stream stalls.
// ----------------------------------------------------------------------------

typedef logic [mexp_pkg::MOD_BITS_DEFAULT-1:0] residue_word;
typedef logic [mexp_pkg::EXP_BITS_DEFAULT-1:0] exponent_word;

class power_scoreboard;
   residue_word  mod_value;
   residue_word  expected_powers[$];
   int           errors;

   function new();
      mod_value = residue_word'(mexp_pkg::MODULUS_RESET);
      errors = 0;
   endfunction

   // base ^ exponent mod mod_value, exponent scanned from the low end
   function residue_word compute_power(residue_word base_value, exponent_word exponent);
      longint unsigned m;
      longint unsigned square;
      longint unsigned partial;
      int              i;
      m = 64'(mod_value);
      if (m < 2) begin
         return '0;
      end
      square = 64'(base_value) % m;
      partial = 1;
      for (i = 0; i < $bits(exponent_word); i++) begin
         if (exponent[i]) begin
            partial = (partial * square) % m;
         end
         square = (square * square) % m;
      end
      return residue_word'(partial);
   endfunction

   function void note_request(residue_word base_value, exponent_word exponent);
      expected_powers.insert(expected_powers.size(), compute_power(base_value, exponent));
   endfunction

   function void check_power(residue_word actual);
      residue_word wanted;
      if (expected_powers.size() == 0) begin
         $error("power: expected none, actual %0d", actual);
         errors++;
      end else begin
         wanted = expected_powers.pop_front();
         if (actual !== wanted) begin
            $error("power: expected %0d, actual %0d", wanted, actual);
            errors++;
         end
      end
   endfunction

   function int pending();
      return expected_powers.size();
   endfunction
endclass

module tb_modular_exponentiation_unit;
   import mexp_pkg::*;

   localparam int MOD_W = MOD_BITS_DEFAULT;
   localparam int EXP_W = EXP_BITS_DEFAULT;
   localparam int REQ_W = ((MOD_W + EXP_W + 7) / 8) * 8;
   localparam int RSP_W = ((MOD_W + 7) / 8) * 8;
   localparam residue_word  BASE_MAX = '1;
   localparam exponent_word EXP_MAX = '1;
   localparam residue_word  RESET_MODULUS = residue_word'(MODULUS_RESET);
   localparam logic [CSR_ADDR_BITS-1:0] MODULUS_ADDR = CSR_ADDR_BITS'(4 * int'(REG_MODULUS));
   localparam int HOLD_AT = 24;
   localparam int HOLD_CYCLES = 20000;
   localparam int ITEM_LATENCY = 4200;
   localparam int unsigned CYCLE_LIMIT = 4000000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_W-1:0]         req_tdata = '0;    // base_value, exponent
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_W-1:0]         rsp_tdata;         // power
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   power_scoreboard sb;
   bit              quiet = 1'b0;
   bit              held = 1'b0;
   int              transfers = 0;
   int unsigned     cycles = 0;

   residue_word directed_base [16] = '{
      '0, BASE_MAX, '0, BASE_MAX, RESET_MODULUS, residue_word'(RESET_MODULUS + 5),
      residue_word'(RESET_MODULUS - 1),
      31'd2, 31'd2, 31'd1, BASE_MAX, 31'd3, 31'd12345, 31'd54321, '0, 31'd7
   };
   exponent_word directed_exp [16] = '{
      '0, '0, 63'd1, 63'd1, 63'd1, 63'd3, 63'd2, 63'd10, EXP_W'(RESET_MODULUS - 1),
      EXP_MAX, EXP_MAX, 63'h4000_0000_0000_0000, 63'h1555_5555_5555_5555,
      63'h2AAA_AAAA_AAAA_AAAA, EXP_MAX, 63'd64
   };

   modular_exponentiation_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_modular_exponentiation_unit: errors");
      $finish;
   end

   task automatic send_item(input residue_word base_value, input exponent_word exponent);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({exponent, base_value});
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      sb.note_request(base_value, exponent);
   endtask

   task automatic send_random(input int count);
      residue_word  b;
      exponent_word e;
      int           r;
      int           k;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 8) b = '0;
         else if (r < 16) b = BASE_MAX;
         else if (r < 26) b = residue_word'(sb.mod_value - 1);
         else if (r < 32) b = sb.mod_value;
         else b = residue_word'($urandom);
         r = $urandom_range(0, 99);
         if (r < 10) begin
            e = '0;
         end else if (r < 15) begin
            e = 63'd1;
         end else if (r < 35) begin
            e = exponent_word'({$urandom, $urandom});
         end else begin
            // short exponents keep most items fast
            k = $urandom_range(2, 12);
            e = (exponent_word'($urandom) & ((exponent_word'(1) << k) - 1))
                | (exponent_word'(1) << (k - 1));
         end
         send_item(b, e);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_modulus_read();
      logic [CSR_DATA_BITS-1:0] value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= MODULUS_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      value = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (value !== CSR_DATA_BITS'(sb.mod_value)) begin
         $error("modulus: expected %0d, actual %0d", sb.mod_value, value);
         sb.errors++;
      end
   endtask

   task automatic program_modulus(input logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MODULUS_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.mod_value = data[MOD_W-1:0];   // bits above the register width drop
      check_modulus_read();
   endtask

   // result side: random stalls, one long hold-off to back up the input
   initial begin
      forever begin
         if (!held && transfers == HOLD_AT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
         if (rsp_tvalid && rsp_tready) begin
            transfers++;
            sb.check_power(rsp_tdata[MOD_W-1:0]);
         end
         @(posedge clock);
      end
   end

   initial begin
      int idx;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      check_modulus_read();

      for (idx = 0; idx < 16; idx++) begin
         send_item(directed_base[idx], directed_exp[idx]);
      end
      send_random(25);
      drain();

      program_modulus(32'h7FFF_FFFF);
      send_random(20);
      drain();

      program_modulus(32'd2);
      send_random(15);
      drain();

      program_modulus(32'hFFFF_FFF3);
      send_random(15);
      drain();

      // modulus below two: every power reads zero
      program_modulus(32'd1);
      send_item(31'd5, '0);
      send_random(5);
      drain();

      program_modulus(32'd0);
      send_item(BASE_MAX, '0);
      send_random(5);
      drain();

      program_modulus(CSR_DATA_BITS'($urandom_range(2, 32'h7FFF_FFFF)));
      send_random(20);
      drain();

      quiet = 1'b1;
      program_modulus(CSR_DATA_BITS'($urandom_range(2, 32'h7FFF_FFFF)));
      send_random(20);
      drain();

      repeat (ITEM_LATENCY) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_modular_exponentiation_unit: clean");
      end else begin
         $display("tb_modular_exponentiation_unit: errors");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/mexp_pkg.sv
rtl/core/modular_exponentiation_unit.sv
tb/sv/tb_modular_exponentiation_unit.sv
